/* design/mfpwd_pkg.sv */
// ----------------------------------------------------------------------------
// mfpwd_pkg
// Shared types and constants of the majority filter pulse width decoder.
// ----------------------------------------------------------------------------
package mfpwd_pkg;

  // sample ring geometry (depth must be a power of two)
  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);

  // field widths
  localparam int unsigned WIN_W      = 8;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // numerator of the estimate update: 7*nominal + 2*estimate + first + second
  localparam int unsigned NUM_W      = 20;

  // divide by ten as multiply by ceil(2^23/10) and shift
  localparam int unsigned DIV_SHIFT  = 23;
  localparam int unsigned RECIP_W    = 20;
  localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(838861);
  localparam int unsigned PROD_W     = NUM_W + RECIP_W;
  localparam int unsigned QUOT_W     = PROD_W - DIV_SHIFT;

  // register reset values
  localparam logic [WIN_W-1:0] WINDOW_RESET  = WIN_W'(31);
  localparam logic [LEN_W-1:0] NOMINAL_RESET = LEN_W'(80);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_LEN = 1'b1;

  // pair decode result handed to the estimate stage
  typedef struct packed {
    logic             valid;
    logic             dec_bit;
    logic [LEN_W-1:0] first_len;
    logic [LEN_W-1:0] second_len;
    logic [NUM_W-1:0] numer;
  } pair_res_t;

endpackage

/* design/mfpwd_window.sv */
// ----------------------------------------------------------------------------
// mfpwd_window
// Sample ring, running window sum and majority vote. The sum is kept
// incrementally; a window size write rebuilds it with a pass over the ring.
// ----------------------------------------------------------------------------
module mfpwd_window (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mfpwd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mfpwd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                accept_i,
  input  logic                                pin_level_i,
  output logic                                level_o,
  output logic                                busy_o
);

  localparam int unsigned AW = mfpwd_pkg::RING_AW;
  localparam int unsigned WW = mfpwd_pkg::WIN_W;

  logic              ring_mem [mfpwd_pkg::RING_DEPTH];

  logic [WW-1:0]     win_q;
  logic [WW-1:0]     sum_q;
  logic [AW-1:0]     wp_q, wp_d;
  logic              full_q, full_d;

  // prefetch of the sample leaving the window
  logic [AW-1:0]     rd_addr;
  logic              rd_ok;
  logic              rd_byp;
  logic              rd_raw_q;
  logic              rd_ok_q;
  logic              rd_byp_q;
  logic              rd_byp_dat_q;
  logic              leaving;

  // rebuild pass
  logic              sw_busy_q;
  logic [WW-1:0]     sw_cnt_q;
  logic              sw_vld_q;
  logic [AW-1:0]     sw_addr;
  logic              sw_ok;
  logic              sw_issue;
  logic              sw_raw_q;
  logic              sw_ok_q;
  logic              sw_data;

  logic              win_wr;
  logic [WW:0]       sum_d;
  logic [WW:0]       threshold;

  assign win_wr = cfg_we_i && (cfg_index_i == mfpwd_pkg::CFG_WINDOW_SIZE);

  // pointer and fill tracking after this cycle's write
  always_comb begin
    wp_d   = accept_i ? wp_q + AW'(1) : wp_q;
    full_d = full_q || (accept_i && (wp_q == AW'(mfpwd_pkg::RING_DEPTH - 1)));
  end

  // next leaving sample address, unwritten entries read as zero
  always_comb begin
    rd_addr = wp_d - win_q[AW-1:0];
    rd_ok   = full_d || (rd_addr < wp_d);
    rd_byp  = accept_i && (rd_addr == wp_q);
  end

  // rebuild pass walks back from the newest sample
  always_comb begin
    sw_addr  = wp_q - AW'(1) - sw_cnt_q[AW-1:0];
    sw_ok    = full_q || (sw_addr < wp_q);
    sw_issue = sw_busy_q && (sw_cnt_q < win_q);
  end

  // ring write and registered reads
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      ring_mem[wp_q] <= pin_level_i;
    end
    rd_raw_q <= ring_mem[rd_addr];
    sw_raw_q <= ring_mem[sw_addr];
  end

  // read qualifiers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q      <= 1'b0;
      rd_byp_q     <= 1'b0;
      rd_byp_dat_q <= 1'b0;
      sw_ok_q      <= 1'b0;
    end else begin
      rd_ok_q      <= rd_ok;
      rd_byp_q     <= rd_byp;
      rd_byp_dat_q <= pin_level_i;
      sw_ok_q      <= sw_ok;
    end
  end

  assign sw_data = sw_ok_q && sw_raw_q;

  // running sum and majority vote for the request being taken
  always_comb begin
    if (win_q == '0) begin
      leaving = pin_level_i;
    end else begin
      leaving = rd_ok_q && (rd_byp_q ? rd_byp_dat_q : rd_raw_q);
    end
    sum_d     = {1'b0, sum_q} + (WW+1)'(pin_level_i) - (WW+1)'(leaving);
    threshold = (WW+1)'(win_q >> 1) + (WW+1)'(1);
    level_o   = (sum_d >= threshold);
  end

  // window state and rebuild sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= mfpwd_pkg::WINDOW_RESET;
      sum_q     <= '0;
      wp_q      <= '0;
      full_q    <= 1'b0;
      sw_busy_q <= 1'b0;
      sw_cnt_q  <= '0;
      sw_vld_q  <= 1'b0;
    end else if (win_wr) begin
      win_q     <= cfg_data_i[WW-1:0];
      sum_q     <= '0;
      sw_busy_q <= 1'b1;
      sw_cnt_q  <= '0;
      sw_vld_q  <= 1'b0;
    end else if (sw_busy_q) begin
      if (sw_issue) begin
        sw_cnt_q <= sw_cnt_q + WW'(1);
      end
      sw_vld_q <= sw_issue;
      if (sw_vld_q) begin
        sum_q <= sum_q + WW'(sw_data);
      end
      if (!sw_issue && !sw_vld_q) begin
        sw_busy_q <= 1'b0;
      end
    end else if (accept_i) begin
      sum_q  <= sum_d[WW-1:0];
      wp_q   <= wp_d;
      full_q <= full_d;
    end
  end

  assign busy_o = sw_busy_q;

endmodule

/* design/mfpwd_pair.sv */
// ----------------------------------------------------------------------------
// mfpwd_pair
// Run length counting and pairing of level changes. Forms the bit, both
// run lengths and the estimate update numerator on the second change.
// ----------------------------------------------------------------------------
module mfpwd_pair (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mfpwd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mfpwd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              accept_i,
  input  logic                              level_i,
  input  logic [mfpwd_pkg::LEN_W-1:0]       estimate_i,
  output mfpwd_pkg::pair_res_t              res_o
);

  localparam int unsigned LW = mfpwd_pkg::LEN_W;
  localparam int unsigned NW = mfpwd_pkg::NUM_W;

  logic [LW-1:0] nominal_q;
  logic          filt_q;
  logic [LW-1:0] run_q;
  logic [LW-1:0] held_q;
  logic          phase_q;
  logic          change;

  assign change = (level_i != filt_q);

  // pair result, with 7*nominal + 2*estimate + first + second
  always_comb begin
    res_o.valid      = accept_i && change && phase_q;
    res_o.dec_bit    = (held_q > run_q);
    res_o.first_len  = held_q;
    res_o.second_len = run_q;
    res_o.numer      = (NW'(nominal_q) << 3) - NW'(nominal_q)
                     + (NW'(estimate_i) << 1)
                     + NW'(held_q) + NW'(run_q);
  end

  // run counter and pair phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nominal_q <= mfpwd_pkg::NOMINAL_RESET;
      filt_q    <= 1'b0;
      run_q     <= '0;
      held_q    <= '0;
      phase_q   <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i == mfpwd_pkg::CFG_NOMINAL_LEN)) begin
        nominal_q <= cfg_data_i[LW-1:0];
      end
      if (accept_i) begin
        if (!change) begin
          run_q <= run_q + LW'(1);
        end else begin
          filt_q  <= level_i;
          run_q   <= '0;
          phase_q <= !phase_q;
          if (!phase_q) begin
            held_q <= run_q;
          end
        end
      end
    end
  end

endmodule

/* design/mfpwd_estimate.sv */
// ----------------------------------------------------------------------------
// mfpwd_estimate
// Divides the update numerator by ten, saturates, keeps the bit length
// estimate and holds the result request until the consumer takes it.
// ----------------------------------------------------------------------------
module mfpwd_estimate (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mfpwd_pkg::pair_res_t          res_i,
  output logic                          free_o,
  output logic [mfpwd_pkg::LEN_W-1:0]   estimate_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          decoded_bit_o,
  output logic [mfpwd_pkg::LEN_W-1:0]   first_length_o,
  output logic [mfpwd_pkg::LEN_W-1:0]   second_length_o,
  output logic [mfpwd_pkg::LEN_W-1:0]   bit_length_estimate_o
);

  localparam int unsigned LW = mfpwd_pkg::LEN_W;

  mfpwd_pkg::pair_res_t              stg_q;
  logic                              stg_vld_q;
  logic                              stg_move;
  logic [mfpwd_pkg::PROD_W-1:0]      prod;
  logic [mfpwd_pkg::QUOT_W-1:0]      quot;
  logic [LW-1:0]                     sat;
  logic [LW-1:0]                     est_new;
  logic [LW-1:0]                     est_q;
  logic                              out_vld_q;

  assign stg_move = stg_vld_q && (!out_vld_q || out_ready_i);
  assign free_o   = !stg_vld_q || stg_move;

  // divide by ten and saturate at the field maximum
  always_comb begin
    prod    = mfpwd_pkg::PROD_W'(stg_q.numer) * mfpwd_pkg::PROD_W'(mfpwd_pkg::DIV_RECIP);
    quot    = prod[mfpwd_pkg::PROD_W-1:mfpwd_pkg::DIV_SHIFT];
    sat     = (quot > mfpwd_pkg::QUOT_W'({LW{1'b1}})) ? {LW{1'b1}} : quot[LW-1:0];
    est_new = stg_q.dec_bit ? sat : est_q;
  end

  // staging register for the decoded pair
  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      stg_q <= res_i;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (stg_move) begin
      decoded_bit_o         <= stg_q.dec_bit;
      first_length_o        <= stg_q.first_len;
      second_length_o       <= stg_q.second_len;
      bit_length_estimate_o <= est_new;
    end
  end

  // control and estimate state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      est_q     <= '0;
    end else begin
      if (res_i.valid) begin
        stg_vld_q <= 1'b1;
      end else if (stg_move) begin
        stg_vld_q <= 1'b0;
      end
      if (stg_move) begin
        out_vld_q <= 1'b1;
        est_q     <= est_new;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign estimate_o  = est_q;
  assign out_valid_o = out_vld_q;

endmodule

/* design/majority_filter_pulse_width_decoder_unit.sv */
// A sample request is taken every cycle unless a rebuild runs or a staged result
// waits behind a held output register; a result request passes a staging register
// and the output register after its closing sample. A window length write rebuilds
// the sum with one ring read a cycle, holding in_ready_o low until that pass ends.
// Reset is asynchronous, active low: control state clears and ring entries read
// as zero until written, tracked by the write pointer and a wrap flag.
// ----------------------------------------------------------------------------
// majority_filter_pulse_width_decoder_unit
// Majority filters the sampled pin, measures run lengths and decodes
// pulse pairs into bits with an adaptive bit length estimate.
// ----------------------------------------------------------------------------
module majority_filter_pulse_width_decoder_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mfpwd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mfpwd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              pin_level_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              decoded_bit_o,
  output logic [mfpwd_pkg::LEN_W-1:0]       first_length_o,
  output logic [mfpwd_pkg::LEN_W-1:0]       second_length_o,
  output logic [mfpwd_pkg::LEN_W-1:0]       bit_length_estimate_o
);

  logic                         accept;
  logic                         level;
  logic                         busy;
  logic                         free;
  logic [mfpwd_pkg::LEN_W-1:0]  estimate;
  mfpwd_pkg::pair_res_t         pair_res;

  // take a sample request unless rebuilding or the staging slot is held
  assign in_ready_o = !busy && free;
  assign accept     = in_valid_i && in_ready_o;

  // majority window
  mfpwd_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .pin_level_i (pin_level_i),
    .level_o     (level),
    .busy_o      (busy)
  );

  // run lengths and pairing
  mfpwd_pair u_pair (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .level_i     (level),
    .estimate_i  (estimate),
    .res_o       (pair_res)
  );

  // estimate update and result register
  mfpwd_estimate u_estimate (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .res_i                 (pair_res),
    .free_o                (free),
    .estimate_o            (estimate),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .decoded_bit_o         (decoded_bit_o),
    .first_length_o        (first_length_o),
    .second_length_o       (second_length_o),
    .bit_length_estimate_o (bit_length_estimate_o)
  );

endmodule
